FILE: hw/rtl/abvg_pkg.sv
`timescale 1ns / 1ps
package abvg_pkg;

	localparam int MAX_SEGMENTS = 256;
	localparam int CORDIC_STEPS = 18;
	localparam int DIV_STEPS = 41;
	localparam logic [32:0] CORDIC_X0 = 33'd652032874;

	typedef enum logic [2:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_MID_RADIUS = 3'd2,
		REG_BAND_WIDTH = 3'd3,
		REG_START_ANGLE = 3'd4,
		REG_END_ANGLE = 3'd5,
		REG_SEGMENT_COUNT = 3'd6
	} reg_idx_t;

	// Divider stage: partial remainder and a dividend that turns into the quotient.
	typedef struct packed {
		logic vld;
		logic ok;
		logic neg;
		logic [8:0] rem;
		logic [DIV_STEPS-1:0] num;
	} div_t;

	typedef struct packed {
		logic vld;
		logic ok;
		logic flip;
		logic [32:0] x;
		logic [32:0] y;
		logic [25:0] z;
	} cordic_t;

	typedef struct packed {
		logic ovf;
		logic ok;
		logic [23:0] oy;
		logic [23:0] ox;
		logic [23:0] iy;
		logic [23:0] ix;
	} res_t;

	function automatic logic [21:0] atan_lut(input logic [4:0] i);
		logic [21:0] r;
		case (i)
			5'd0: r = 22'd2097152;
			5'd1: r = 22'd1238021;
			5'd2: r = 22'd654136;
			5'd3: r = 22'd332050;
			5'd4: r = 22'd166669;
			5'd5: r = 22'd83416;
			5'd6: r = 22'd41718;
			5'd7: r = 22'd20860;
			5'd8: r = 22'd10430;
			5'd9: r = 22'd5215;
			5'd10: r = 22'd2608;
			5'd11: r = 22'd1304;
			5'd12: r = 22'd652;
			5'd13: r = 22'd326;
			5'd14: r = 22'd163;
			5'd15: r = 22'd81;
			5'd16: r = 22'd41;
			5'd17: r = 22'd20;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/abvg_div_cell.sv
`timescale 1ns / 1ps
module abvg_div_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [8:0] divisor,
	input  abvg_pkg::div_t d_in,
	output abvg_pkg::div_t d_out
);
	abvg_pkg::div_t d_q;
	logic [9:0] trial;
	logic ge;
	logic [9:0] nrem;

	always_comb begin
		trial = {d_in.rem, d_in.num[abvg_pkg::DIV_STEPS-1]};
		ge = trial >= {1'b0, divisor};
		nrem = ge ? (trial - {1'b0, divisor}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q.vld <= 1'b0;
		end else if (en) begin
			d_q.vld <= d_in.vld;
			d_q.ok <= d_in.ok;
			d_q.neg <= d_in.neg;
			d_q.rem <= nrem[8:0];
			d_q.num <= {d_in.num[abvg_pkg::DIV_STEPS-2:0], ge};
		end
	end

	assign d_out = d_q;
endmodule

FILE: hw/rtl/abvg_cordic_cell.sv
`timescale 1ns / 1ps
module abvg_cordic_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [4:0] step,
	input  abvg_pkg::cordic_t c_in,
	output abvg_pkg::cordic_t c_out
);
	abvg_pkg::cordic_t c_q;
	logic signed [32:0] xs, ys, nx, ny;
	logic signed [25:0] at, nz;

	always_comb begin
		xs = $signed(c_in.x) >>> step;
		ys = $signed(c_in.y) >>> step;
		at = $signed({4'b0, abvg_pkg::atan_lut(step)});
		if (!c_in.z[25]) begin
			nx = $signed(c_in.x) - ys;
			ny = $signed(c_in.y) + xs;
			nz = $signed(c_in.z) - at;
		end else begin
			nx = $signed(c_in.x) + ys;
			ny = $signed(c_in.y) - xs;
			nz = $signed(c_in.z) + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q.vld <= 1'b0;
		end else if (en) begin
			c_q.vld <= c_in.vld;
			c_q.ok <= c_in.ok;
			c_q.flip <= c_in.flip;
			c_q.x <= nx;
			c_q.y <= ny;
			c_q.z <= nz;
		end
	end

	assign c_out = c_q;
endmodule

FILE: hw/rtl/abvg_coord.sv
`timescale 1ns / 1ps
module abvg_coord (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  abvg_pkg::cordic_t c_in,
	input  logic [23:0] center_x,
	input  logic [23:0] center_y,
	input  logic [25:0] inner2,
	input  logic [25:0] outer2,
	output logic res_vld,
	output abvg_pkg::res_t res
);
	logic vld_s1, ok_s1, vld_s2, ok_s2, vld_s3;
	logic signed [17:0] cos_s1, sin_s1;
	logic signed [43:0] pix_s2, piy_s2, pox_s2, poy_s2;
	abvg_pkg::res_t res_s3;
	logic signed [32:0] xr, yr, xn, yn;
	logic [24:0] six, siy, sox, soy;

	function automatic logic [24:0] place(input logic [23:0] c, input logic signed [43:0] p);
		logic signed [43:0] t;
		logic signed [27:0] v;
		logic [24:0] r;
		t = (p + 44'sd65536) >>> 17;
		v = $signed({{4{c[23]}}, c}) + $signed({t[26], t[26:0]});
		if (v > 28'sd8388607) r = {1'b1, 24'h7FFFFF};
		else if (v < -28'sd8388608) r = {1'b1, 24'h800000};
		else r = {1'b0, v[23:0]};
		return r;
	endfunction

	always_comb begin
		xr = ($signed(c_in.x) + 33'sd8192) >>> 14;
		yr = ($signed(c_in.y) + 33'sd8192) >>> 14;
		xn = c_in.flip ? -xr : xr;
		yn = c_in.flip ? -yr : yr;
		six = place(center_x, pix_s2);
		siy = place(center_y, piy_s2);
		sox = place(center_x, pox_s2);
		soy = place(center_y, poy_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= c_in.vld;
			ok_s1 <= c_in.ok;
			cos_s1 <= xn[17:0];
			sin_s1 <= yn[17:0];
			vld_s2 <= vld_s1;
			ok_s2 <= ok_s1;
			pix_s2 <= $signed(inner2) * cos_s1;
			piy_s2 <= $signed(inner2) * sin_s1;
			pox_s2 <= $signed(outer2) * cos_s1;
			poy_s2 <= $signed(outer2) * sin_s1;
			vld_s3 <= vld_s2;
			// An index beyond the segment count gives an all-zero result.
			if (ok_s2) begin
				res_s3.ix <= six[23:0];
				res_s3.iy <= siy[23:0];
				res_s3.ox <= sox[23:0];
				res_s3.oy <= soy[23:0];
				res_s3.ovf <= six[24] | siy[24] | sox[24] | soy[24];
				res_s3.ok <= 1'b1;
			end else begin
				res_s3 <= '0;
			end
		end
	end

	assign res_vld = vld_s3;
	assign res = res_s3;
endmodule

FILE: hw/rtl/arc_band_vertex_generator_core.sv
`timescale 1ns / 1ps
// The result of an input transfer reaches m_tdata/m_tuser through 65 register
// stages in a row.
// Throughput: one item per cycle while the skid register is empty, set by the chain
// of 41 divider cells, 18 CORDIC cells and the coordinate stages, all of which advance together.
// A skid register beside the output register keeps input flowing for one more item.
// Reset (arst_n low) empties the pipeline and loads the register reset values.
module arc_band_vertex_generator_core (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [15:0] s_tdata, // [8:0] vertex_index
	output logic m_tvalid,
	input  logic m_tready,
	output logic [95:0] m_tdata, // [23:0] inner_x, [47:24] inner_y, [71:48] outer_x, [95:72] outer_y
	output logic [1:0] m_tuser, // [0] index_valid, [1] overflowed
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int ND = abvg_pkg::DIV_STEPS;
	localparam int NC = abvg_pkg::CORDIC_STEPS;

	logic [23:0] center_x_q, center_y_q;
	logic [22:0] mid_radius_q, band_width_q;
	logic [31:0] start_angle_q, end_angle_q;
	logic [8:0] segment_count_q;
	logic [8:0] segs;
	logic en;

	abvg_pkg::div_t div_s[ND+1];
	abvg_pkg::cordic_t cor_s[NC+1];
	abvg_pkg::res_t res, out_q, skid_q;
	logic res_vld, out_vld_q, skid_vld_q;

	logic signed [32:0] diff;
	logic signed [42:0] prod;
	logic [42:0] mag;
	logic [8:0] idx;
	logic [15:0] q16, a16;
	logic signed [25:0] zw, zp;
	logic flip;
	logic [25:0] inner2, outer2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			mid_radius_q <= '0;
			band_width_q <= '0;
			start_angle_q <= '0;
			end_angle_q <= '0;
			segment_count_q <= 9'd32;
		end else if (cfg_valid) begin
			case (abvg_pkg::reg_idx_t'(cfg_index))
				abvg_pkg::REG_CENTER_X: center_x_q <= cfg_data[23:0];
				abvg_pkg::REG_CENTER_Y: center_y_q <= cfg_data[23:0];
				abvg_pkg::REG_MID_RADIUS: mid_radius_q <= cfg_data[22:0];
				abvg_pkg::REG_BAND_WIDTH: band_width_q <= cfg_data[22:0];
				abvg_pkg::REG_START_ANGLE: start_angle_q <= cfg_data;
				abvg_pkg::REG_END_ANGLE: end_angle_q <= cfg_data;
				abvg_pkg::REG_SEGMENT_COUNT: segment_count_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (segment_count_q == 9'd0) segs = 9'd1;
		else if (segment_count_q > 9'(abvg_pkg::MAX_SEGMENTS)) segs = 9'(abvg_pkg::MAX_SEGMENTS);
		else segs = segment_count_q;
		inner2 = {2'b0, mid_radius_q, 1'b0} - {3'b0, band_width_q};
		outer2 = {2'b0, mid_radius_q, 1'b0} + {3'b0, band_width_q};
	end

	// The whole chain advances unless the skid register holds an item.
	assign en = !skid_vld_q;
	assign s_tready = en;

	always_comb begin
		idx = s_tdata[8:0];
		diff = $signed({end_angle_q[31], end_angle_q}) - $signed({start_angle_q[31], start_angle_q});
		prod = $signed({1'b0, idx}) * diff;
		mag = prod[42] ? 43'(-prod) : prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s[0].vld <= 1'b0;
		end else if (en) begin
			div_s[0].vld <= s_tvalid;
			div_s[0].ok <= idx <= segs;
			div_s[0].neg <= prod[42];
			div_s[0].rem <= '0;
			div_s[0].num <= mag[ND-1:0];
		end
	end

	for (genvar k = 0; k < ND; k++) begin : g_div
		abvg_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .divisor(segs),
			.d_in(div_s[k]), .d_out(div_s[k+1])
		);
	end

	// Only the low 16 quotient bits matter once the angle wraps per turn.
	always_comb begin
		q16 = div_s[ND].num[15:0];
		a16 = start_angle_q[15:0] + (div_s[ND].neg ? 16'(16'd0 - q16) : q16);
		zw = $signed({{2{a16[15]}}, a16, 8'h00});
		flip = 1'b0;
		zp = zw;
		if (zw > 26'sd4194304) begin
			zp = zw - 26'sd8388608;
			flip = 1'b1;
		end else if (zw < -26'sd4194304) begin
			zp = zw + 26'sd8388608;
			flip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cor_s[0].vld <= 1'b0;
		end else if (en) begin
			cor_s[0].vld <= div_s[ND].vld;
			cor_s[0].ok <= div_s[ND].ok;
			cor_s[0].flip <= flip;
			cor_s[0].x <= abvg_pkg::CORDIC_X0;
			cor_s[0].y <= '0;
			cor_s[0].z <= zp;
		end
	end

	for (genvar k = 0; k < NC; k++) begin : g_cor
		abvg_cordic_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .step(5'(k)),
			.c_in(cor_s[k]), .c_out(cor_s[k+1])
		);
	end

	abvg_coord u_coord (
		.clk(clk), .arst_n(arst_n), .en(en), .c_in(cor_s[NC]),
		.center_x(center_x_q), .center_y(center_y_q),
		.inner2(inner2), .outer2(outer2),
		.res_vld(res_vld), .res(res)
	);

	// While the skid register is full the chain is frozen, so the item at its end
	// is still waiting and must not be taken again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (m_tready || !out_vld_q) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
				out_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_q <= res;
				out_vld_q <= res_vld;
			end
		end else if (res_vld && !skid_vld_q) begin
			skid_q <= res;
			skid_vld_q <= 1'b1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = {out_q.oy, out_q.ox, out_q.iy, out_q.ix};
	assign m_tuser = {out_q.ovf, out_q.ok};

	a_stall_only_behind_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid) else $error("input stalled with empty output");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
		else $error("invalid index with nonzero result");
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !m_tready))
		else $error("skid filled while output free");
endmodule
